[sv/cbkr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbkr_pkg
// Shared types and constants of the cubic B-spline knot removal block.
// ----------------------------------------------------------------------------
package cbkr_pkg;
   localparam int MaxKnots   = 64;
   localparam int MaxColumns = 64;
   localparam int MaxDim     = 4;
   localparam int FracBits   = 16;

   localparam logic [1:0] KIND_WR_KNOT = 2'd0;
   localparam logic [1:0] KIND_WR_COEF = 2'd1;
   localparam logic [1:0] KIND_RD_KNOT = 2'd2;
   localparam logic [1:0] KIND_RD_COEF = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SPAN  = 2'd2;
   localparam logic [1:0] ST_ALPHA = 2'd3;

   localparam logic [1:0] REG_REMOVE = 2'd0;
   localparam logic [1:0] REG_KNOTS  = 2'd1;
   localparam logic [1:0] REG_COEFS  = 2'd2;
   localparam logic [1:0] REG_DIM    = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE, S_KRD, S_KWAIT, S_CRD, S_CWAIT,
      S_K0, S_K1, S_K2, S_A1, S_A1W, S_C4, S_C5, S_P1, S_D1, S_D1W,
      S_K3, S_K4, S_A2, S_A2W, S_C3, S_P2, S_D2, S_D2W, S_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic signed [63:0] num;
      logic signed [63:0] den;
   } div_req_type;
endpackage

[sv/cbkr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbkr_div
// Iterative fixed-point divider: trunc(n*2^F/d), saturated to 32 bits.
// ----------------------------------------------------------------------------
module cbkr_div import cbkr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               busy,
   output logic signed [31:0] quot
);
   localparam int Steps = 48 + FracBits;

   logic [63:0] ud_ff, ud_in;
   logic [63:0] rem_ff, rem_in;
   logic [Steps-1:0] q_ff, q_in;
   logic [63:0] un_ff, un_in;
   logic neg_ff, neg_in;
   logic [6:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic [64:0] trial;

   always_comb begin
      ud_in = ud_ff; rem_in = rem_ff; q_in = q_ff; un_in = un_ff;
      neg_in = neg_ff; cnt_in = cnt_ff; run_in = run_ff;
      trial = {rem_ff, 1'b0};
      if (req.start) begin
         neg_in = req.num[63] ^ req.den[63];
         un_in  = req.num[63] ? 64'(-req.num) : req.num;
         ud_in  = req.den[63] ? 64'(-req.den) : req.den;
         rem_in = '0;
         q_in   = '0;
         cnt_in = 7'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // one bit of (un << F) per cycle, numerator bits 47 down to 0 then F zeros
         trial = {rem_ff, (cnt_ff < 7'd48) ? un_ff[6'(7'd47 - cnt_ff)] : 1'b0};
         if (trial >= {1'b0, ud_ff}) begin
            rem_in = 64'(trial - {1'b0, ud_ff});
            q_in   = {q_ff[Steps-2:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            q_in   = {q_ff[Steps-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(Steps - 1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      ud_ff <= ud_in; rem_ff <= rem_in; q_ff <= q_in; un_ff <= un_in; neg_ff <= neg_in;
   end

   assign busy = run_ff | req.start;

   always_comb begin
      if (neg_ff) quot = (q_ff > Steps'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-q_ff);
      else        quot = (q_ff > Steps'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q_ff[31:0];
   end
endmodule

[sv/cubic_bspline_knot_removal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_knot_removal
// Knot and coefficient stores with reduced-spline readout after removing
// one knot of a cubic B-spline.
// ----------------------------------------------------------------------------
// Usage: requests enter on req_* (tuser = kind, tdata = column, component,
// value). Writes fill the knot or coefficient store and give no response.
// Reads give one response on rsp_* (tdata = result_value, status).
// Config registers sit on csr_* at byte addresses 0,4,8,12.
// A write leaves the sequencer idle, so the next request can follow at once.
// A knot read or a copy read passes a read state, a wait state and the
// output state before rsp_tvalid rises; the next request waits for it.
// The first recomputed column takes two passes of the 64-step iterative
// divider and the second takes four (alpha and blend quotients in turn).
// One request at a time: req_tready is low while a request is in work or a
// response is waiting. A stalled receiver holds the response in the output
// register until taken. Reset restores registers 5,8,4,1 and idles the
// sequencer; store contents stay undefined until written.
// ----------------------------------------------------------------------------
module cubic_bspline_knot_removal import cbkr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: column[5:0], component[7:6], value[39:8]
   input  logic [39:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: result_value[31:0], status[33:32], zero fill
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [5:0] rem_ff; logic [6:0] kc_ff, cc_ff; logic [2:0] dim_ff;
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 6'd5; kc_ff <= 7'd8; cc_ff <= 7'd4; dim_ff <= 3'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_REMOVE: rem_ff <= csr_pwdata[5:0];
            REG_KNOTS:  kc_ff  <= csr_pwdata[6:0];
            REG_COEFS:  cc_ff  <= csr_pwdata[6:0];
            REG_DIM:    dim_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[3:2])
         REG_REMOVE: csr_prdata = {26'd0, rem_ff};
         REG_KNOTS:  csr_prdata = {25'd0, kc_ff};
         REG_COEFS:  csr_prdata = {25'd0, cc_ff};
         default:    csr_prdata = {29'd0, dim_ff};
      endcase
   end

   // stores
   logic [31:0] kmem [MaxKnots];
   logic [31:0] cmem [MaxColumns*MaxDim];
   logic [5:0] kaddr; logic [7:0] caddr;
   logic signed [31:0] krd_ff, crd_ff;

   state_type st_ff, st_in;
   logic [5:0] col_ff, col_in; logic [1:0] cmp_ff, cmp_in;
   logic signed [63:0] acc_ff, acc_in;   // scratch: knot u, differences, coefficients
   logic signed [63:0] dn_ff, dn_in;
   logic signed [31:0] a_ff, a_in, t1_ff, t1_in, c_ff, c_in;
   logic [31:0] res_ff, res_in; logic [1:0] stat_ff, stat_in;
   logic ov_ff, ov_in;
   div_req_type dreq; logic dbusy; logic signed [31:0] dq;

   cbkr_div u_div (.clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quot(dq));

   wire accept = req_tvalid & req_tready;
   wire [5:0] icol = req_tdata[5:0];
   wire [1:0] icmp = req_tdata[7:6];
   wire [6:0] r7 = {1'b0, rem_ff};
   wire geo = (r7 >= 7'd5) && (r7 + 7'd2 <= kc_ff) && (kc_ff <= 7'(MaxKnots)) &&
              (r7 - 7'd1 <= cc_ff) && (cc_ff <= 7'(MaxColumns)) &&
              (dim_ff >= 3'd1) && (dim_ff <= 3'(MaxDim));
   // weight and product of the blend, one multiplier
   logic signed [33:0] w; logic signed [31:0] ws; logic signed [63:0] prod;
   always_comb begin
      w  = 34'sd65536 - 34'(a_ff);
      ws = (w > 34'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
           (w < -34'sh8000_0000) ? 32'sh8000_0000 : w[31:0];
      prod = 64'(ws) * 64'(c_ff);
   end

   assign req_tready = (st_ff == S_IDLE) && !ov_ff;

   always_comb begin
      st_in = st_ff; col_in = col_ff; cmp_in = cmp_ff;
      acc_in = acc_ff; dn_in = dn_ff; a_in = a_ff; t1_in = t1_ff; c_in = c_ff;
      res_in = res_ff; stat_in = stat_ff; ov_in = ov_ff;
      kaddr = col_ff; caddr = {col_ff, cmp_ff};
      dreq = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: if (accept) begin
            col_in = icol; cmp_in = icmp;
            if (req_tuser == KIND_RD_KNOT || req_tuser == KIND_RD_COEF) begin
               res_in = '0; stat_in = ST_OK;
               if (!geo) begin stat_in = ST_RANGE; st_in = S_OUT; end
               else if (req_tuser == KIND_RD_KNOT) begin
                  if (7'(icol) + 7'd1 >= kc_ff) begin stat_in = ST_RANGE; st_in = S_OUT; end
                  else begin
                     col_in = (7'(icol) < r7 - 7'd1) ? icol : 6'(icol + 6'd1);
                     st_in = S_KRD;
                  end
               end else if (7'(icol) + 7'd1 >= cc_ff || 3'(icmp) >= dim_ff) begin
                  stat_in = ST_RANGE; st_in = S_OUT;
               end else if (7'(icol) < r7 - 7'd4) st_in = S_CRD;
               else if (7'(icol) >= r7 - 7'd2) begin
                  col_in = 6'(icol + 6'd1); st_in = S_CRD;
               end else st_in = S_K0;
            end
         end
         S_KRD:   st_in = S_KWAIT;
         S_KWAIT: begin res_in = krd_ff; st_in = S_OUT; end
         S_CRD:   st_in = S_CWAIT;
         S_CWAIT: begin res_in = crd_ff; st_in = S_OUT; end
         // alpha1: K[r-1]-K[r-4] over K[r]-K[r-4]
         S_K0: begin kaddr = 6'(rem_ff - 6'd1); st_in = S_K1; end
         S_K1: begin kaddr = 6'(rem_ff - 6'd4); acc_in = 64'(krd_ff); st_in = S_K2; end
         S_K2: begin kaddr = rem_ff; st_in = S_A1;
            acc_in = acc_ff - 64'(krd_ff); dn_in = -64'(krd_ff); end
         S_A1: begin
            dn_in = dn_ff + 64'(krd_ff);
            if (dn_ff + 64'(krd_ff) == 0) begin stat_in = ST_SPAN; st_in = S_OUT; end
            else begin
               dreq.start = 1'b1; dreq.num = acc_ff; dreq.den = dn_ff + 64'(krd_ff);
               st_in = S_A1W;
            end
         end
         S_A1W: if (!dbusy) begin
            a_in = dq;
            if (dq == 0) begin stat_in = ST_ALPHA; st_in = S_OUT; end
            else st_in = S_C4;
         end
         S_C4: begin caddr = {6'(rem_ff - 6'd4), cmp_ff}; st_in = S_C5; end
         S_C5: begin caddr = {6'(rem_ff - 6'd5), cmp_ff}; acc_in = 64'(crd_ff); st_in = S_P1; end
         S_P1: begin c_in = crd_ff; st_in = S_D1; end
         S_D1: begin
            dreq.start = 1'b1; dreq.num = acc_ff - (prod >>> FracBits);
            dreq.den = 64'(a_ff); st_in = S_D1W;
         end
         S_D1W: if (!dbusy) begin
            t1_in = dq;
            if (7'(col_ff) == r7 - 7'd4) begin res_in = dq; st_in = S_OUT; end
            else begin kaddr = 6'(rem_ff - 6'd1); st_in = S_K3; end
         end
         // alpha2: K[r-1]-K[r-3] over K[r+1]-K[r-3]
         S_K3: begin kaddr = 6'(rem_ff - 6'd3); acc_in = 64'(krd_ff); st_in = S_K4; end
         S_K4: begin kaddr = 6'(rem_ff + 6'd1); st_in = S_A2;
            acc_in = acc_ff - 64'(krd_ff); dn_in = -64'(krd_ff); end
         S_A2: begin
            if (dn_ff + 64'(krd_ff) == 0) begin stat_in = ST_SPAN; st_in = S_OUT; end
            else begin
               dreq.start = 1'b1; dreq.num = acc_ff; dreq.den = dn_ff + 64'(krd_ff);
               st_in = S_A2W;
            end
         end
         S_A2W: if (!dbusy) begin
            a_in = dq; c_in = t1_ff;
            if (dq == 0) begin stat_in = ST_ALPHA; st_in = S_OUT; end
            else begin caddr = {6'(rem_ff - 6'd3), cmp_ff}; st_in = S_C3; end
         end
         S_C3: st_in = S_P2;
         S_P2: begin acc_in = 64'(crd_ff); st_in = S_D2; end
         S_D2: begin
            dreq.start = 1'b1; dreq.num = acc_ff - (prod >>> FracBits);
            dreq.den = 64'(a_ff); st_in = S_D2W;
         end
         S_D2W: if (!dbusy) begin res_in = dq; st_in = S_OUT; end
         S_OUT: if (!ov_ff) begin
            if (stat_ff != ST_OK) res_in = '0;
            ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
      end
      col_ff <= col_in; cmp_ff <= cmp_in; acc_ff <= acc_in;
      dn_ff <= dn_in; a_ff <= a_in; t1_ff <= t1_in; c_ff <= c_in;
      res_ff <= res_in; stat_ff <= stat_in;
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == KIND_WR_KNOT) kmem[icol] <= req_tdata[39:8];
      if (accept && req_tuser == KIND_WR_COEF) cmem[{icol, icmp}] <= req_tdata[39:8];
      krd_ff <= kmem[kaddr];
      crd_ff <= cmem[caddr];
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {6'd0, stat_ff, res_ff};
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cubic_bspline_knot_removal. Requests are driven on
// the req_* stream and predicted by a local model of the knot removal
// arithmetic. Each response on rsp_* is compared field by field with the
// oldest predicted element. Both stream sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb import cbkr_pkg::*; ;

   typedef struct {
      logic [1:0]  kind;
      logic [5:0]  column;
      logic [1:0]  component;
      logic [31:0] value;
   } spline_req_type;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  status;
   } spline_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // column[5:0], component[7:6], value[39:8]
   logic [1:0]  req_tuser = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // result_value[31:0], status[33:32], zero fill
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // local copy of the block's state
   longint       knot_mem [MaxKnots];
   longint       coef_mem [MaxColumns*MaxDim];
   int           remove_reg = 5;
   int           knots_reg  = 8;
   int           coefs_reg  = 4;
   int           dim_reg    = 1;

   spline_elem_type elem_q [$];
   int           fail_count = 0;
   bit           hold_rsp   = 1'b0;
   bit           no_idle    = 1'b0;

   always #10 clock = ~clock;

   cubic_bspline_knot_removal i_dut (.*);

   // ------------------------------------------------------------------------
   // Arithmetic of the reduced spline
   // ------------------------------------------------------------------------
   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // trunc(n * 2^FracBits / d), saturated to 32 bits
   function automatic longint fix_div(longint n, longint d);
      bit                neg;
      longint unsigned   un, ud, q, rem;
      neg = (n < 0) != (d < 0);
      un  = (n < 0) ? longint'(-n) : n;
      ud  = (d < 0) ? longint'(-d) : d;
      q   = un / ud;
      rem = un % ud;
      if (q >= 64'h1_0000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
      for (int i = 0; i < FracBits; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= ud) begin
            rem = rem - ud;
            q   = q | 1;
         end
      end
      if (neg) return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
      return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
   endfunction

   // alpha over knots lo..hi; status ST_OK when usable
   function automatic logic [1:0] knot_alpha(int lo, int hi, output longint alpha);
      longint den;
      alpha = 0;
      den   = knot_mem[hi] - knot_mem[lo];
      if (den == 0) return ST_SPAN;
      alpha = fix_div(knot_mem[remove_reg-1] - knot_mem[lo], den);
      if (alpha == 0) return ST_ALPHA;
      return ST_OK;
   endfunction

   function automatic longint blend(longint a, longint alpha, longint prev);
      longint w;
      w = sat32((64'sd1 << FracBits) - alpha);
      return fix_div(a - ((w * prev) >>> FracBits), alpha);
   endfunction

   function automatic spline_elem_type reduced_elem(spline_req_type rq);
      spline_elem_type e;
      int           r, col, comp;
      longint       res, a1, a2, t1;
      logic [1:0]   st;
      r   = remove_reg;
      col = rq.column;
      comp = rq.component;
      res = 0;
      st  = ST_OK;
      if (!(r >= 5 && r + 2 <= knots_reg && knots_reg <= MaxKnots &&
            r - 1 <= coefs_reg && coefs_reg <= MaxColumns &&
            dim_reg >= 1 && dim_reg <= MaxDim)) begin
         st = ST_RANGE;
      end else if (rq.kind == KIND_RD_KNOT) begin
         if (col + 1 >= knots_reg) st = ST_RANGE;
         else res = knot_mem[(col < r - 1) ? col : col + 1];
      end else if (col + 1 >= coefs_reg || comp >= dim_reg) begin
         st = ST_RANGE;
      end else if (col < r - 4) begin
         res = coef_mem[col*MaxDim + comp];
      end else if (col >= r - 2) begin
         res = coef_mem[(col+1)*MaxDim + comp];
      end else begin
         // the two recomputed columns around the removed knot
         st = knot_alpha(r - 4, r, a1);
         if (st == ST_OK) begin
            t1 = blend(coef_mem[(r-4)*MaxDim + comp], a1, coef_mem[(r-5)*MaxDim + comp]);
            if (col == r - 4) begin
               res = t1;
            end else begin
               st = knot_alpha(r - 3, r + 1, a2);
               if (st == ST_OK) res = blend(coef_mem[(r-3)*MaxDim + comp], a2, t1);
            end
         end
         if (st != ST_OK) res = 0;
      end
      e.value  = res[31:0];
      e.status = st;
      return e;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_req(spline_req_type rq);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.kind;
      req_tdata  <= {rq.value, rq.component, rq.column};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge: update the local stores or predict
      case (rq.kind)
         KIND_WR_KNOT: knot_mem[rq.column] = longint'($signed(rq.value));
         KIND_WR_COEF: coef_mem[rq.column*MaxDim + rq.component] =
                          longint'($signed(rq.value));
         default:      elem_q.push_back(reduced_elem(rq));
      endcase
   endtask

   task automatic write_req(logic [1:0] kind, int col, int comp, logic [31:0] val);
      spline_req_type rq;
      rq.kind = kind; rq.column = 6'(col); rq.component = 2'(comp); rq.value = val;
      send_req(rq);
   endtask

   task automatic read_req(logic [1:0] kind, int col, int comp);
      write_req(kind, col, comp, $urandom());
   endtask

   // drain outstanding responses; writes leave no trace, so pad a little
   task automatic wait_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (elem_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_REMOVE: remove_reg = val & 32'h3F;
         REG_KNOTS:  knots_reg  = val & 32'h7F;
         REG_COEFS:  coefs_reg  = val & 32'h7F;
         default:    dim_reg    = val & 32'h7;
      endcase
   endtask

   task automatic set_geometry(int r, int kc, int cc, int d);
      wait_idle();
      csr_write(REG_REMOVE, r);
      csr_write(REG_KNOTS, kc);
      csr_write(REG_COEFS, cc);
      csr_write(REG_DIM, d);
   endtask

   // non-decreasing knots; zero steps give the odd zero span
   task automatic load_knots(int lo, int hi);
      int k;
      k = $signed($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      for (int i = lo; i <= hi; i++) begin
         write_req(KIND_WR_KNOT, i, 0, k);
         k += ($urandom_range(0, 3) << FracBits) + $urandom_range(0, 16'hFFFF);
      end
   endtask

   function automatic logic [31:0] coef_value();
      if ($urandom_range(0, 1)) return $urandom();
      return $signed($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
   endfunction

   task automatic load_coefs(int lo, int hi);
      for (int c = lo; c <= hi; c++)
         for (int p = 0; p < MaxDim; p++) write_req(KIND_WR_COEF, c, p, coef_value());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // every entry written once so that no read hits an empty slot
   task automatic test_fill();
      load_knots(0, MaxKnots - 1);
      load_coefs(0, MaxColumns - 1);
   endtask

   task automatic test_reset_geometry();
      for (int c = 0; c < 8; c++) read_req(KIND_RD_KNOT, c, 0);
      for (int c = 0; c < 4; c++) read_req(KIND_RD_COEF, c, 0);
      read_req(KIND_RD_COEF, 0, 1);
   endtask

   task automatic test_bad_geometry();
      set_geometry(4, 8, 4, 1);
      read_req(KIND_RD_KNOT, 0, 0);
      set_geometry(5, 6, 4, 1);
      read_req(KIND_RD_COEF, 1, 0);
      set_geometry(61, 65, 64, 4);
      read_req(KIND_RD_KNOT, 3, 0);
      set_geometry(10, 20, 8, 1);
      read_req(KIND_RD_COEF, 0, 0);
      set_geometry(10, 20, 12, 0);
      read_req(KIND_RD_COEF, 0, 0);
      set_geometry(10, 20, 65, 5);
      read_req(KIND_RD_KNOT, 0, 0);
   endtask

   task automatic test_directed();
      int r;
      set_geometry(5, 8, 4, 4);
      read_req(KIND_RD_KNOT, 0, 0);
      read_req(KIND_RD_KNOT, 5, 0);
      read_req(KIND_RD_KNOT, 7, 0);              // out of range
      read_req(KIND_RD_COEF, 1, 3);
      read_req(KIND_RD_COEF, 3, 0);              // out of range
      set_geometry(61, 64, 64, 4);
      r = 61;
      read_req(KIND_RD_KNOT, 62, 0);
      read_req(KIND_RD_COEF, r - 4, 3);
      read_req(KIND_RD_COEF, r - 3, 3);
      read_req(KIND_RD_COEF, 62, 2);
      set_geometry(20, 30, 25, 2);
      r = 20;
      // saturating quotients from extreme coefficients
      write_req(KIND_WR_COEF, r - 4, 0, 32'h7FFF_FFFF);
      write_req(KIND_WR_COEF, r - 5, 0, 32'h8000_0000);
      read_req(KIND_RD_COEF, r - 4, 0);
      read_req(KIND_RD_COEF, r - 3, 0);
      read_req(KIND_RD_COEF, r - 4, 2);          // component beyond dimension
      // zero alpha: the removed knot equals the lower end
      write_req(KIND_WR_KNOT, r - 1, 0, 32'(knot_mem[r-4]));
      read_req(KIND_RD_COEF, r - 4, 1);
      // zero span
      write_req(KIND_WR_KNOT, r, 0, 32'(knot_mem[r-4]));
      read_req(KIND_RD_COEF, r - 3, 1);
      load_knots(0, MaxKnots - 1);
   endtask

   task automatic test_random();
      int r, kc, cc, n;
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 0) begin
            r = 5;  kc = 7 + 2 * 0 + 0; kc = 8; cc = 4;
         end else if (ph == 1) begin
            r = 61; kc = 64; cc = 64;
         end else begin
            r  = $urandom_range(5, 61);
            kc = $urandom_range(r + 2, 64);
            cc = $urandom_range(r - 1, 64);
         end
         set_geometry(r, kc, cc, (ph % 4) + 1);
         no_idle = (ph % 3 == 2);
         load_knots(r - 5, r + 1);
         load_coefs(r - 5, r - 3);
         n = 0;
         while (n < 85) begin
            case ($urandom_range(0, 9))
               0: write_req(KIND_WR_KNOT, $urandom_range(0, 63), $urandom_range(0, 3),
                            $urandom());
               1: write_req(KIND_WR_COEF, $urandom_range(0, 63), $urandom_range(0, 3),
                            coef_value());
               2, 3: read_req(KIND_RD_KNOT, $urandom_range(0, 63), $urandom_range(0, 3));
               4, 5: read_req(KIND_RD_COEF, $urandom_range(0, 63), $urandom_range(0, 3));
               default: read_req(KIND_RD_COEF, r - 4 + $urandom_range(0, 1),
                                 $urandom_range(0, dim_reg - 1));
            endcase
            n++;
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      set_geometry(12, 40, 30, 3);
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++) read_req(KIND_RD_COEF, $urandom_range(6, 12), 0);
   endtask

   // ------------------------------------------------------------------------
   // Response checker; the receiver's stalls live here too
   // ------------------------------------------------------------------------
   initial begin : rsp_check
      int           stall;
      spline_elem_type exp_e;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (elem_q.size() == 0) begin
            $error("response with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_e = elem_q.pop_front();
            if (rsp_tdata[31:0] !== exp_e.value) begin
               $error("result_value: expected %h, got %h", exp_e.value, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[33:32] !== exp_e.status) begin
               $error("status: expected %0d, got %0d", exp_e.status, rsp_tdata[33:32]);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #200ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : main
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill();
      test_reset_geometry();
      test_bad_geometry();
      test_directed();
      test_random();
      test_backpressure();
      wait_idle();
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
sv/cbkr_pkg.sv
sv/cbkr_div.sv
sv/cubic_bspline_knot_removal.sv
test/tb.sv
